### sv/rmq_pkg.sv
`timescale 1ns / 1ps
package rmq_pkg;
   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;
endpackage

### sv/rmq_sqrt_cell.sv
`timescale 1ns / 1ps
// one root bit per cell: restoring square root, remainder and root move to the next cell
module rmq_sqrt_cell #(
   parameter int AW = 48,
   parameter int RW = 24,
   parameter int BITPOS = 0
) (
   input  logic          clock,
   input  logic          en,
   input  logic [AW-1:0] rem_i,
   input  logic [RW-1:0] root_i,
   output logic [AW-1:0] rem_o,
   output logic [RW-1:0] root_o
);
   logic [AW+1:0] trial;
   logic [AW-1:0] rem_in;
   logic [RW-1:0] root_in;
   logic [AW-1:0] rem_ff;
   logic [RW-1:0] root_ff;

   always_comb begin
      trial   = ({2'b00, rem_i} >> (2 * BITPOS))
                - {({{(AW+2-RW){1'b0}}, root_i} << 2) | (AW+2)'(1)};
      rem_in  = rem_i;
      root_in = root_i << 1;
      if (!trial[AW+1]) begin
         rem_in  = rem_i - AW'((trial[AW-1:0] ^ trial[AW-1:0]) +
                   (({{(AW-RW){1'b0}}, root_i} << 2 | AW'(1)) << (2 * BITPOS)));
         root_in = (root_i << 1) | RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
endmodule

### sv/rmq_div_cell.sv
`timescale 1ns / 1ps
// one quotient bit per cell for the three off-diagonal components
module rmq_div_cell #(
   parameter int NW = 48,
   parameter int DVW = 26,
   parameter int BITPOS = 0
) (
   input  logic                clock,
   input  logic                en,
   input  logic [DVW-1:0]      dvs,
   input  logic [2:0][NW-1:0]  rem_i,
   input  logic [2:0][NW-1:0]  quo_i,
   output logic [2:0][NW-1:0]  rem_o,
   output logic [2:0][NW-1:0]  quo_o
);
   logic [2:0][NW-1:0] rem_in, quo_in;
   logic [2:0][NW-1:0] rem_ff, quo_ff;
   logic [NW+DVW-1:0]  shd;

   always_comb begin
      shd = {{NW{1'b0}}, dvs} << BITPOS;
      for (int k = 0; k < 3; k++) begin
         rem_in[k] = rem_i[k];
         quo_in[k] = quo_i[k];
         if ({{DVW{1'b0}}, rem_i[k]} >= shd) begin
            rem_in[k] = rem_i[k] - shd[NW-1:0];
            quo_in[k] = quo_i[k] | (NW'(1) << BITPOS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
endmodule

### sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// Rotation matrix to quaternion by Shepperd's method, signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
// Fully pipelined: one matrix is accepted every cycle while the pipe advances; each
// result passes the input register, the square root cell row (one root bit per cell),
// the divider cell row (one quotient bit per cell) and the output register. The whole
// pipe advances while the output register is empty or being taken, so rsp_stall
// holds every stage. degenerate flags a non-positive root argument or a zero root;
// the components are then zero.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_m00, req_m01, req_m02,
   input  logic signed [DATA_WIDTH-1:0] req_m10, req_m11, req_m12,
   input  logic signed [DATA_WIDTH-1:0] req_m20, req_m21, req_m22,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw,
   output logic [1:0]                   rsp_case_taken,
   output logic                         rsp_degenerate
);
   localparam int SW = DATA_WIDTH + 3;               // branch sums
   localparam int AW = DATA_WIDTH + FRAC_BITS + 2;   // root argument
   localparam int SQN = (AW + 1) / 2;                // root bits
   localparam int RW = SQN;
   localparam int NW = DATA_WIDTH + 1 + FRAC_BITS;   // |num| << frac
   localparam int QB = NW;                           // quotient bits
   localparam int DVW = RW + 1;
   localparam int LAT = 1 + SQN + QB;

   logic en;
   logic [LAT-1:0] vld_ff;
   logic out_vld_ff;
   assign en = !out_vld_ff || !rsp_stall;
   assign req_stall = !en;

   // stage 1: branch select and sums
   logic signed [SW-1:0] e00, e11, e22, tr, arg_in;
   logic [1:0] br_in;
   logic signed [SW-1:0] n0_in, n1_in, n2_in;
   always_comb begin
      e00 = SW'(req_m00); e11 = SW'(req_m11); e22 = SW'(req_m22);
      tr = e00 + e11 + e22;
      if (tr > 0) begin
         br_in = BR_TRACE; arg_in = tr + (SW'(1) <<< FRAC_BITS);
      end else if (e00 > e11 && e00 > e22) begin
         br_in = BR_X; arg_in = (SW'(1) <<< FRAC_BITS) + e00 - e11 - e22;
      end else if (e11 > e22) begin
         br_in = BR_Y; arg_in = (SW'(1) <<< FRAC_BITS) + e11 - e00 - e22;
      end else begin
         br_in = BR_Z; arg_in = (SW'(1) <<< FRAC_BITS) + e22 - e00 - e11;
      end
      case (br_in)
         BR_TRACE: begin
            n0_in = SW'(req_m21) - SW'(req_m12);
            n1_in = SW'(req_m02) - SW'(req_m20);
            n2_in = SW'(req_m10) - SW'(req_m01);
         end
         BR_X: begin
            n0_in = SW'(req_m21) - SW'(req_m12);
            n1_in = SW'(req_m01) + SW'(req_m10);
            n2_in = SW'(req_m02) + SW'(req_m20);
         end
         BR_Y: begin
            n0_in = SW'(req_m02) - SW'(req_m20);
            n1_in = SW'(req_m01) + SW'(req_m10);
            n2_in = SW'(req_m12) + SW'(req_m21);
         end
         default: begin
            n0_in = SW'(req_m10) - SW'(req_m01);
            n1_in = SW'(req_m02) + SW'(req_m20);
            n2_in = SW'(req_m12) + SW'(req_m21);
         end
      endcase
   end

   logic [AW-1:0] sq_arg_ff;
   logic degen_ff;
   logic [1:0] br_ff;
   logic [2:0] neg_ff;
   logic [2:0][NW-1:0] mag_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff  <= (arg_in <= 0);
         sq_arg_ff <= (arg_in > 0) ? AW'(arg_in[SW-2:0]) << FRAC_BITS : '0;
         br_ff     <= br_in;
         neg_ff    <= {n2_in[SW-1], n1_in[SW-1], n0_in[SW-1]};
         mag_ff[0] <= NW'(n0_in[SW-1] ? -n0_in : n0_in) << FRAC_BITS;
         mag_ff[1] <= NW'(n1_in[SW-1] ? -n1_in : n1_in) << FRAC_BITS;
         mag_ff[2] <= NW'(n2_in[SW-1] ? -n2_in : n2_in) << FRAC_BITS;
      end
   end

   // square root cell row with side data carried alongside
   logic [SQN:0][AW-1:0] sq_rem;
   logic [SQN:0][RW-1:0] sq_root;
   logic [SQN:0] sd_degen;
   logic [SQN:0][1:0] sd_br;
   logic [SQN:0][2:0] sd_neg;
   logic [SQN:0][2:0][NW-1:0] sd_mag;
   assign sq_rem[0] = sq_arg_ff;
   assign sq_root[0] = '0;
   assign sd_degen[0] = degen_ff;
   assign sd_br[0] = br_ff;
   assign sd_neg[0] = neg_ff;
   assign sd_mag[0] = mag_ff;
   for (genvar i = 0; i < SQN; i++) begin : g_sq
      rmq_sqrt_cell #(.AW(AW), .RW(RW), .BITPOS(SQN - 1 - i)) u_cell (
         .clock (clock), .en(en),
         .rem_i (sq_rem[i]), .root_i(sq_root[i]),
         .rem_o (sq_rem[i+1]), .root_o(sq_root[i+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            sd_degen[i+1] <= sd_degen[i];
            sd_br[i+1]    <= sd_br[i];
            sd_neg[i+1]   <= sd_neg[i];
            sd_mag[i+1]   <= sd_mag[i];
         end
      end
   end

   // divider cell row
   logic [QB:0][2:0][NW-1:0] dv_rem, dv_quo;
   logic [QB:0][DVW-1:0] dv_d;
   logic [QB:0][RW-1:0] dv_h;
   logic [QB:0] dv_degen;
   logic [QB:0][1:0] dv_br;
   logic [QB:0][2:0] dv_neg;
   assign dv_rem[0] = sd_mag[SQN];
   assign dv_quo[0] = '0;
   assign dv_h[0] = sq_root[SQN];
   assign dv_d[0] = {sq_root[SQN], 1'b0};
   assign dv_degen[0] = sd_degen[SQN] || (sq_root[SQN] == '0);
   assign dv_br[0] = sd_br[SQN];
   assign dv_neg[0] = sd_neg[SQN];
   for (genvar j = 0; j < QB; j++) begin : g_dv
      rmq_div_cell #(.NW(NW), .DVW(DVW), .BITPOS(QB - 1 - j)) u_cell (
         .clock (clock), .en(en), .dvs(dv_d[j]),
         .rem_i (dv_rem[j]), .quo_i(dv_quo[j]),
         .rem_o (dv_rem[j+1]), .quo_o(dv_quo[j+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            dv_d[j+1]     <= dv_d[j];
            dv_h[j+1]     <= dv_h[j];
            dv_degen[j+1] <= dv_degen[j];
            dv_br[j+1]    <= dv_br[j];
            dv_neg[j+1]   <= dv_neg[j];
         end
      end
   end

   function automatic logic [DATA_WIDTH-1:0] sat(input logic neg, input logic [NW-1:0] mag);
      logic [NW-1:0] lim;
      logic [NW-1:0] m;
      begin
         lim = NW'(1) << (DATA_WIDTH - 1);
         m = mag;
         if (neg) begin
            if (m > lim) m = lim;
            sat = DATA_WIDTH'(-m);
         end else begin
            if (m > lim - NW'(1)) m = lim - NW'(1);
            sat = DATA_WIDTH'(m);
         end
      end
   endfunction

   logic [DATA_WIDTH-1:0] big, c0, c1, c2;
   logic [DATA_WIDTH-1:0] qx_in, qy_in, qz_in, qw_in;
   always_comb begin
      big = sat(1'b0, NW'(dv_h[QB] >> 1));
      c0 = sat(dv_neg[QB][0], dv_quo[QB][0]);
      c1 = sat(dv_neg[QB][1], dv_quo[QB][1]);
      c2 = sat(dv_neg[QB][2], dv_quo[QB][2]);
      case (dv_br[QB])
         BR_TRACE: begin qw_in = big; qx_in = c0; qy_in = c1; qz_in = c2; end
         BR_X:     begin qw_in = c0; qx_in = big; qy_in = c1; qz_in = c2; end
         BR_Y:     begin qw_in = c0; qx_in = c1; qy_in = big; qz_in = c2; end
         default:  begin qw_in = c0; qx_in = c1; qy_in = c2; qz_in = big; end
      endcase
      if (dv_degen[QB]) begin
         qx_in = '0; qy_in = '0; qz_in = '0; qw_in = '0;
      end
   end

   logic [DATA_WIDTH-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   logic [1:0] case_ff;
   logic dg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
         out_vld_ff <= vld_ff[LAT-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         qx_ff <= qx_in; qy_ff <= qy_in; qz_ff <= qz_in; qw_ff <= qw_in;
         case_ff <= dv_br[QB];
         dg_ff <= dv_degen[QB];
      end
   end
   assign rsp_valid = out_vld_ff;
   assign rsp_qx = qx_ff;
   assign rsp_qy = qy_ff;
   assign rsp_qz = qz_ff;
   assign rsp_qw = qw_ff;
   assign rsp_case_taken = case_ff;
   assign rsp_degenerate = dg_ff;
endmodule

### sv/rmq_checker.sv
`timescale 1ns / 1ps
module rmq_checker #(
   parameter int DATA_WIDTH = 16
) (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic signed [DATA_WIDTH-1:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw,
   input logic rsp_degenerate
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_qx) && $stable(rsp_qw))
      else $error("stalled result changed");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_qx == 0 && rsp_qy == 0 && rsp_qz == 0 && rsp_qw == 0)
      else $error("degenerate result not zero");
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");
   a_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");
endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (.*);
